// File: src/clnw_pkg.sv
// Shared types, request codes and helper functions for the character LCD nibble writer.
// Depends on nothing; every other file of the block imports it.
package clnw_pkg;

	typedef enum logic [2:0] {
		CMD_BYTE    = 3'd0,
		CMD_CHAR    = 3'd1,
		CMD_CURSOR  = 3'd2,
		CMD_PRINT   = 3'd3,
		CMD_STARTUP = 3'd4
	} cmd_t;

	localparam logic [7:0] ROW_ONE      = 8'd1;
	localparam logic [7:0] ROW_TWO      = 8'd2;
	localparam logic [7:0] LINE1_BASE   = 8'h80;
	localparam logic [7:0] LINE2_BASE   = 8'hC0;
	localparam logic [7:0] HOME_CMD     = 8'h80;
	localparam logic [7:0] ASCII_ZERO   = 8'd48;
	localparam logic [7:0] ASCII_ERROR  = 8'h45;
	localparam logic [3:0] DIGITS_MAX   = 4'd5;
	localparam int         FRAME_BYTES  = 6;
	localparam int         FRAME_NIBS   = 2 * FRAME_BYTES;
	localparam int         NUM_DIGITS   = 5;

	// Start-up bytes, sent from index 0 (the rightmost, 8'h33) upward; the framer bit-reverses every nibble with rev4.
	localparam logic [FRAME_BYTES-1:0][7:0] STARTUP_BYTES = {
		8'h80, 8'h0C, 8'h01, 8'h28, 8'h32, 8'h33
	};

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] byte_value;
		logic [7:0] row;
		logic [7:0] column;
		logic [3:0] digit_count;
	} req_t;

	typedef logic [NUM_DIGITS-1:0][3:0] digits_t;

	typedef struct packed {
		logic [3:0] pins;
		logic       rs;
	} strobe_t;

	function automatic logic [3:0] rev4(input logic [3:0] n);
		return {n[0], n[1], n[2], n[3]};
	endfunction

	function automatic logic [3:0] dec_digit(input logic [15:0] value, input logic [15:0] step);
		logic [3:0] d;
		d = '0;
		for (int k = 1; k <= 9; k++) begin
			if ({1'b0, value} >= 17'(17'(k) * {1'b0, step})) begin
				d = 4'(k);
			end
		end
		return d;
	endfunction

	function automatic logic [15:0] dec_rem(input logic [15:0] value, input logic [15:0] step,
			input logic [3:0] d);
		return value - 16'(20'(d) * 20'(step));
	endfunction

endpackage

// File: src/char_lcd_nibble_writer_top.sv
// Top level of the character LCD nibble writer: decimal split pipeline and strobe framer.
// Depends on clnw_pkg, clnw_decimal and clnw_framer.
//
// A request enters on the input channel (in_valid/in_ready) with command, byte_value, row,
// column, number and digit_count. Each request becomes zero to twelve result transfers on
// the output channel (out_valid/out_ready), one 4-bit strobe per transfer, with last set on
// the final strobe of the request. A request that yields no strobes produces no transfer.
// From the input transfer to the first strobe on out_valid a request passes an input
// register, two digit stages, a third digit stage and the frame register. The frame register
// then delivers one strobe per cycle while out_ready is high, so a request takes the output
// for twice its byte count in strobes, up to twelve; that output shift register bounds the
// sustained rate. Requests queue in the four pipeline stages, and the next frame loads in the
// same cycle that the previous frame's last strobe is taken, so frames follow without a gap.
// When out_ready is low the frame holds and the pipeline fills; in_ready falls once all four
// stages hold a request. Reset clears all valid flags and the frame count; no output is valid
// after reset.
module char_lcd_nibble_writer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [7:0]  byte_value,
	input  logic [7:0]  row,
	input  logic [7:0]  column,
	input  logic [15:0] number,
	input  logic [3:0]  digit_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  pin_nibble,
	output logic        register_select,
	output logic        last
);
	import clnw_pkg::*;

	req_t    in_req;
	req_t    dec_req;
	digits_t dec_digits;
	logic    dec_valid;
	logic    dec_take;

	assign in_req = '{command: command, byte_value: byte_value, row: row, column: column,
		digit_count: digit_count};

	clnw_decimal u_decimal (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_req     (in_req),
		.in_number  (number),
		.dec_valid  (dec_valid),
		.dec_take   (dec_take),
		.dec_req    (dec_req),
		.dec_digits (dec_digits)
	);

	clnw_framer u_framer (
		.clk             (clk),
		.arst_n          (arst_n),
		.dec_valid       (dec_valid),
		.dec_take        (dec_take),
		.dec_req         (dec_req),
		.dec_digits      (dec_digits),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.pin_nibble      (pin_nibble),
		.register_select (register_select),
		.last            (last)
	);

	// The input side can only stall when the last pipeline stage holds a request.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> dec_valid)
		else $error("input stalled with an empty last stage");

	// A strobe that is not the last of its request is always followed by more strobes.
	a_frame_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |=> out_valid)
		else $error("frame ended before its last strobe");

	// After the last strobe is taken the output empties unless a new frame loads.
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last && out_ready && !dec_valid) |=> !out_valid)
		else $error("output still valid after the final transfer");

endmodule

// File: src/clnw_decimal.sv
// Input register and decimal split pipeline: three stages that peel off decimal digits.
// Depends on clnw_pkg.
module clnw_decimal (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  clnw_pkg::req_t   in_req,
	input  logic [15:0]      in_number,
	output logic             dec_valid,
	input  logic             dec_take,
	output clnw_pkg::req_t   dec_req,
	output clnw_pkg::digits_t dec_digits
);
	import clnw_pkg::*;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic        en1, en2, en3, en4;
	req_t        req_s1, req_s2, req_s3, req_s4;
	logic [15:0] number_s1;
	logic [3:0]  d4_s2, d4_s3, d3_s3;
	logic [13:0] r4_s2;
	logic [9:0]  r3_s3;
	digits_t     digits_s4;

	logic [3:0]  d4_c, d3_c, d2_c, d1_c;
	logic [15:0] r4_c, r3_c, r2_c;

	assign en4 = !v_s4 || dec_take;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_comb begin
		d4_c = dec_digit(number_s1, 16'd10000);
		r4_c = dec_rem(number_s1, 16'd10000, d4_c);
		d3_c = dec_digit({2'b00, r4_s2}, 16'd1000);
		r3_c = dec_rem({2'b00, r4_s2}, 16'd1000, d3_c);
		d2_c = dec_digit({6'd0, r3_s3}, 16'd100);
		r2_c = dec_rem({6'd0, r3_s3}, 16'd100, d2_c);
		d1_c = dec_digit(r2_c, 16'd10);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			req_s1    <= in_req;
			number_s1 <= in_number;
		end
		if (en2 && v_s1) begin
			req_s2 <= req_s1;
			d4_s2  <= d4_c;
			r4_s2  <= r4_c[13:0];
		end
		if (en3 && v_s2) begin
			req_s3 <= req_s2;
			d4_s3  <= d4_s2;
			d3_s3  <= d3_c;
			r3_s3  <= r3_c[9:0];
		end
		if (en4 && v_s3) begin
			req_s4       <= req_s3;
			digits_s4[4] <= d4_s3;
			digits_s4[3] <= d3_s3;
			digits_s4[2] <= d2_c;
			digits_s4[1] <= d1_c;
			digits_s4[0] <= 4'(r2_c - 16'(d1_c) * 16'd10);
		end
	end

	assign dec_valid  = v_s4;
	assign dec_req    = req_s4;
	assign dec_digits = digits_s4;

endmodule

// File: src/clnw_framer.sv
// Builds the strobe list of one request and shifts it out one nibble per transfer.
// Depends on clnw_pkg.
module clnw_framer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              dec_valid,
	output logic              dec_take,
	input  clnw_pkg::req_t    dec_req,
	input  clnw_pkg::digits_t dec_digits,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [3:0]        pin_nibble,
	output logic              register_select,
	output logic              last
);
	import clnw_pkg::*;

	logic [FRAME_BYTES-1:0][7:0] fb;
	logic [FRAME_BYTES-1:0]      frs;
	logic [2:0]                  nb;
	logic [2:0]                  off;
	logic [2:0]                  slot;
	logic [2:0]                  didx;
	logic [7:0]                  cur_byte;
	logic                        row_ok;
	strobe_t [FRAME_NIBS-1:0]    nibs_c;
	strobe_t [FRAME_NIBS-1:0]    frame_q;
	logic [3:0]                  cnt_q;
	logic                        free;
	logic                        load;
	logic                        xfer;

	always_comb begin
		fb       = '0;
		frs      = '0;
		nb       = '0;
		off      = '0;
		slot     = '0;
		didx     = '0;
		row_ok   = (dec_req.row == ROW_ONE) || (dec_req.row == ROW_TWO);
		cur_byte = ((dec_req.row == ROW_ONE) ? LINE1_BASE : LINE2_BASE) + dec_req.column - 8'd1;
		unique case (cmd_t'(dec_req.command))
			CMD_BYTE: begin
				fb[0] = dec_req.byte_value;
				nb    = 3'd1;
			end
			CMD_CHAR: begin
				fb[0]  = dec_req.byte_value;
				frs[0] = 1'b1;
				nb     = 3'd1;
			end
			CMD_CURSOR: begin
				if (row_ok) begin
					fb[0] = cur_byte;
					nb    = 3'd1;
				end
			end
			CMD_PRINT: begin
				if (dec_req.row == 8'd0 || dec_req.column == 8'd0) begin
					fb[0] = HOME_CMD;
					off   = 3'd1;
				end else if (row_ok) begin
					fb[0] = cur_byte;
					off   = 3'd1;
				end
				if (dec_req.digit_count > DIGITS_MAX) begin
					fb[off]  = ASCII_ERROR;
					frs[off] = 1'b1;
					nb       = off + 3'd1;
				end else begin
					for (int k = 0; k < NUM_DIGITS; k++) begin
						if (4'(k) < dec_req.digit_count) begin
							slot      = off + 3'(k);
							didx      = 3'(dec_req.digit_count - 4'd1 - 4'(k));
							fb[slot]  = ASCII_ZERO + {4'd0, dec_digits[didx]};
							frs[slot] = 1'b1;
						end
					end
					nb = off + dec_req.digit_count[2:0];
				end
			end
			CMD_STARTUP: begin
				fb = STARTUP_BYTES;
				nb = 3'(FRAME_BYTES);
			end
			default: begin
				nb = '0;
			end
		endcase
		for (int b = 0; b < FRAME_BYTES; b++) begin
			nibs_c[2*b]     = '{pins: rev4(fb[b][7:4]), rs: frs[b]};
			nibs_c[2*b + 1] = '{pins: rev4(fb[b][3:0]), rs: frs[b]};
		end
	end

	assign xfer     = (cnt_q != 4'd0) && out_ready;
	assign free     = (cnt_q == 4'd0) || ((cnt_q == 4'd1) && out_ready);
	assign load     = dec_valid && free;
	assign dec_take = free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= {nb, 1'b0};
		end else if (xfer) begin
			cnt_q <= cnt_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= nibs_c;
		end else if (xfer) begin
			for (int i = 0; i < FRAME_NIBS - 1; i++) begin
				frame_q[i] <= frame_q[i + 1];
			end
		end
	end

	assign out_valid       = (cnt_q != 4'd0);
	assign pin_nibble      = frame_q[0].pins;
	assign register_select = frame_q[0].rs;
	assign last            = (cnt_q == 4'd1);

endmodule
